>>> rtl/core/enbb3_pkg.sv
// Shared constants, types and state codes for the 3x3 edge-normalized box mean.
// No dependencies; compiled first.
package enbb3_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 1024;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int ADDR_W     = $clog2(MAX_COLS);
    localparam int FCNT_W     = ADDR_W + 1;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;
    localparam int SUM_W      = SAMPLE_W + 4;
    localparam int MAG_W      = SUM_W - 1;
    localparam int CNT_W      = 4;
    localparam int RECIP_SH   = SUM_W;
    localparam int RECIP_W    = SUM_W + 1;
    localparam int RECIP_ONE  = 1 << RECIP_SH;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_JOB_A,
        ST_JOB_B,
        ST_FL_RD,
        ST_FL_SH,
        ST_FL_JOB
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } t_meta;

    typedef struct packed {
        logic       valid;
        logic [2:0] rm;
        logic [2:0] cm;
        t_meta      meta;
    } t_job;

endpackage

>>> rtl/core/enbb3_pix_if.sv
// Input stream channel: one pixel word per handshake.
// Depends on enbb3_pkg.
interface enbb3_pix_if;
    import enbb3_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

>>> rtl/core/enbb3_res_if.sv
// Result stream channel: one smoothed pixel word per handshake.
// Depends on enbb3_pkg.
interface enbb3_res_if;
    import enbb3_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] smoothed_value;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_col;
    logic                       last_of_burst;
    logic                       frame_done;

    modport source (output valid, output smoothed_value, output out_row, output out_col,
                    output last_of_burst, output frame_done, input ready);
    modport sink   (input valid, input smoothed_value, input out_row, input out_col,
                    input last_of_burst, input frame_done, output ready);
endinterface

>>> rtl/core/edge_normalized_box_blur_3x3_unit.sv
// A pixel word accepted in idle passes the window update, 3x3 sum, rounding add,
// reciprocal multiply and correction registers before its first result word reaches
// the output register. A new pixel is taken only back in idle, once the last one's
// result jobs have entered the mean pipeline; the frame's final pixel adds a flush
// over every column. The line store read port and the shared mean pipeline set the
// rate; a stalled output holds the sequencer. Reset (i_rst_n low, synchronous) clears
// control, positions and config; line store has no reset.
module edge_normalized_box_blur_3x3_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    enbb3_pix_if.sink                        i_pix,
    enbb3_res_if.source                      o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [enbb3_pkg::PADDR_W-1:0]    paddr,
    input  logic [enbb3_pkg::PDATA_W-1:0]    pwdata,
    output logic [enbb3_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import enbb3_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ROWS_CFG_W-1:0] r_frame_rows;
    logic [COLS_CFG_W-1:0] r_frame_cols;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= ROWS_CFG_W'(24);
            r_frame_cols <= COLS_CFG_W'(MAX_COLS);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_frame_rows <= pwdata[ROWS_CFG_W-1:0];
            end else begin
                r_frame_cols <= pwdata[COLS_CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ROWS) begin
            prdata = PDATA_W'(r_frame_rows);
        end else begin
            prdata = PDATA_W'(r_frame_cols);
        end
    end

    // Effective frame size: zero counts as one, oversize clamps to the max.
    logic [ROWS_CFG_W-1:0] rows_eff;
    logic [FCNT_W-1:0]     cols_eff;
    logic [ROW_W-1:0]      last_row;
    logic [COL_W-1:0]      last_col;

    always_comb begin
        if (r_frame_rows == '0) begin
            rows_eff = ROWS_CFG_W'(1);
        end else if (r_frame_rows > ROWS_CFG_W'(MAX_ROWS)) begin
            rows_eff = ROWS_CFG_W'(MAX_ROWS);
        end else begin
            rows_eff = r_frame_rows;
        end
        if (r_frame_cols == '0) begin
            cols_eff = FCNT_W'(1);
        end else if (FCNT_W'(r_frame_cols) > FCNT_W'(MAX_COLS)) begin
            cols_eff = FCNT_W'(MAX_COLS);
        end else begin
            cols_eff = FCNT_W'(r_frame_cols);
        end
    end

    assign last_row = ROW_W'(rows_eff - ROWS_CFG_W'(1));
    assign last_col = COL_W'(cols_eff - FCNT_W'(1));

    // ---------------------------------------------------------------
    // Raster position of the next pixel
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] cur_c;
    logic             cur_final;
    logic             accept;

    assign cur_r     = (r_row > last_row) ? '0 : r_row;
    assign cur_c     = (r_col > last_col) ? '0 : r_col;
    assign cur_final = (cur_r == last_row) && (cur_c == last_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_wr) begin
            r_row <= '0;      // any register write starts a new frame
            r_col <= '0;
        end else if (accept) begin
            if (cur_final) begin
                r_row <= '0;
                r_col <= '0;
            end else if (cur_c == last_col) begin
                r_row <= cur_r + ROW_W'(1);
                r_col <= '0;
            end else begin
                r_row <= cur_r;
                r_col <= cur_c + COL_W'(1);
            end
        end
    end

    // Per-pixel context, captured at acceptance.
    logic signed [SAMPLE_W-1:0] r_px;
    logic [ROW_W-1:0]           r_cur_row;
    logic [COL_W-1:0]           r_cur_col;
    logic                       r_need_a;   // centered result one row/col behind
    logic                       r_need_b;   // right edge result at row end
    logic                       r_final;    // last pixel of the frame: flush row
    logic                       r_row_ge1;
    logic                       r_row_ge2;
    logic                       r_col_ge1;
    logic                       r_col_ge2;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px      <= i_pix.pixel_value;
            r_cur_row <= cur_r;
            r_cur_col <= cur_c;
            r_need_a  <= (cur_r != '0) && (cur_c != '0);
            r_need_b  <= (cur_r != '0) && (cur_c == last_col);
            r_final   <= cur_final;
            r_row_ge1 <= cur_r >= ROW_W'(1);
            r_row_ge2 <= cur_r >= ROW_W'(2);
            r_col_ge1 <= cur_c >= COL_W'(1);
            r_col_ge2 <= cur_c >= COL_W'(2);
        end
    end

    // ---------------------------------------------------------------
    // Line store: one entry per column, {row R-2 sample, row R-1 sample}.
    // One read and one write port, read data registered.
    // ---------------------------------------------------------------
    logic [2*SAMPLE_W-1:0] r_mem [MAX_COLS];
    logic [2*SAMPLE_W-1:0] r_rdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cur_col[ADDR_W-1:0]] <= {r_rdata[SAMPLE_W-1:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------
    // 3x3 window: column 2 is newest. During the flush the two line
    // store rows stream through rows 0 and 1; row 2 is masked then.
    // ---------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] r_win [3][3];
    logic                       win_shift;

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rdata[2*SAMPLE_W-1:SAMPLE_W];
            r_win[1][2] <= r_rdata[SAMPLE_W-1:0];
            r_win[2][2] <= r_px;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [FCNT_W-1:0] r_f;        // flush sweep column (reads column r_f)
    logic              f_clr;
    logic              f_inc;
    logic              adv;        // mean pipeline moves this cycle
    t_job              job;

    assign accept = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_f     <= '0;
        end else begin
            r_state <= n_state;
            if (f_clr) begin
                r_f <= '0;
            end else if (f_inc) begin
                r_f <= r_f + FCNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        i_pix.ready = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = cur_c[ADDR_W-1:0];
        mem_we      = 1'b0;
        win_shift   = 1'b0;
        f_clr       = 1'b0;
        f_inc       = 1'b0;
        job         = '0;
        case (r_state)
            ST_IDLE: begin
                i_pix.ready = 1'b1;
                if (i_pix.valid) begin
                    mem_re  = 1'b1;
                    f_clr   = 1'b1;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                win_shift = 1'b1;
                mem_we    = 1'b1;
                if (r_need_a) begin
                    n_state = ST_JOB_A;
                end else if (r_need_b) begin
                    n_state = ST_JOB_B;
                end else if (r_final) begin
                    n_state = ST_FL_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_JOB_A: begin
                job.rm        = {1'b1, 1'b1, r_row_ge2};
                job.cm        = {1'b1, 1'b1, r_col_ge2};
                job.meta.row  = r_cur_row - ROW_W'(1);
                job.meta.col  = r_cur_col - COL_W'(1);
                job.meta.last = !r_need_b && !r_final;
                if (adv) begin
                    job.valid = 1'b1;
                    if (r_need_b) begin
                        n_state = ST_JOB_B;
                    end else if (r_final) begin
                        n_state = ST_FL_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_JOB_B: begin
                // right edge: previous and current column, nothing to the right
                job.rm        = {1'b1, 1'b1, r_row_ge2};
                job.cm        = {1'b1, r_col_ge1, 1'b0};
                job.meta.row  = r_cur_row - ROW_W'(1);
                job.meta.col  = r_cur_col;
                job.meta.last = !r_final;
                if (adv) begin
                    job.valid = 1'b1;
                    n_state   = r_final ? ST_FL_RD : ST_IDLE;
                end
            end
            ST_FL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_f[ADDR_W-1:0];
                n_state   = ST_FL_SH;
            end
            ST_FL_SH: begin
                win_shift = 1'b1;
                if (r_f != '0) begin
                    n_state = ST_FL_JOB;
                end else begin
                    f_inc   = 1'b1;
                    n_state = ST_FL_RD;
                end
            end
            ST_FL_JOB: begin
                // centered on column r_f-1; rows R-1 (if any) and R only
                job.rm        = {1'b0, 1'b1, r_row_ge1};
                job.cm        = {r_f < cols_eff, 1'b1, r_f >= FCNT_W'(2)};
                job.meta.row  = r_cur_row;
                job.meta.col  = COL_W'(r_f - FCNT_W'(1));
                job.meta.last = (r_f == cols_eff);
                job.meta.done = (r_f == cols_eff);
                if (adv) begin
                    job.valid = 1'b1;
                    if (r_f == cols_eff) begin
                        n_state = ST_IDLE;
                    end else begin
                        f_inc   = 1'b1;
                        n_state = ST_FL_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Mean pipeline. Every stage and the output register move together
    // on adv, so a stalled output freezes the whole pipe.
    // ---------------------------------------------------------------
    logic r_out_v;
    assign adv = !r_out_v || o_res.ready;

    // stage 1: masked window sum and cell count
    logic signed [SUM_W-1:0] sum_c;
    logic [CNT_W-1:0]        cnt_c;
    logic [1:0]              nrows;
    logic [1:0]              ncols;

    always_comb begin
        sum_c = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (job.rm[i] && job.cm[j]) begin
                    sum_c = sum_c + SUM_W'(r_win[i][j]);
                end
            end
        end
        nrows = 2'({1'b0, job.rm[0]} + {1'b0, job.rm[1]} + {1'b0, job.rm[2]});
        ncols = 2'({1'b0, job.cm[0]} + {1'b0, job.cm[1]} + {1'b0, job.cm[2]});
        cnt_c = CNT_W'(nrows) * CNT_W'(ncols);
    end

    logic                    r_s1_v;
    logic signed [SUM_W-1:0] r_s1_sum;
    logic [CNT_W-1:0]        r_s1_cnt;
    t_meta                   r_s1_meta;

    // stage 2: magnitude plus half the count (round half away from zero)
    logic [SUM_W-1:0] abs_sum;
    logic [MAG_W-1:0] x_c;

    assign abs_sum = r_s1_sum[SUM_W-1] ? SUM_W'(-r_s1_sum) : SUM_W'(r_s1_sum);
    assign x_c     = abs_sum[MAG_W-1:0] + MAG_W'(r_s1_cnt >> 1);

    logic             r_s2_v;
    logic [MAG_W-1:0] r_s2_x;
    logic [CNT_W-1:0] r_s2_cnt;
    logic             r_s2_neg;
    t_meta            r_s2_meta;

    // stage 3: quotient estimate by reciprocal, low by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
        case (c)
            CNT_W'(1): recip = RECIP_W'(RECIP_ONE);
            CNT_W'(2): recip = RECIP_W'(RECIP_ONE / 2);
            CNT_W'(3): recip = RECIP_W'(RECIP_ONE / 3);
            CNT_W'(4): recip = RECIP_W'(RECIP_ONE / 4);
            CNT_W'(6): recip = RECIP_W'(RECIP_ONE / 6);
            CNT_W'(9): recip = RECIP_W'(RECIP_ONE / 9);
            default:   recip = '0;
        endcase
    endfunction

    logic [MAG_W+RECIP_W-1:0] prod;
    assign prod = (MAG_W+RECIP_W)'(r_s2_x) * (MAG_W+RECIP_W)'(recip(r_s2_cnt));

    logic             r_s3_v;
    logic [MAG_W-1:0] r_s3_q0;
    logic [MAG_W-1:0] r_s3_x;
    logic [CNT_W-1:0] r_s3_cnt;
    logic             r_s3_neg;
    t_meta            r_s3_meta;

    // stage 4: correction step and sign
    logic [MAG_W+CNT_W-1:0] qc;
    logic [MAG_W-1:0]       rem;
    logic [MAG_W-1:0]       q_fix;
    logic [MAG_W-1:0]       q_sgn;

    assign qc    = (MAG_W+CNT_W)'(r_s3_q0) * (MAG_W+CNT_W)'(r_s3_cnt);
    assign rem   = r_s3_x - qc[MAG_W-1:0];
    assign q_fix = (rem >= MAG_W'(r_s3_cnt)) ? r_s3_q0 + MAG_W'(1) : r_s3_q0;
    assign q_sgn = r_s3_neg ? MAG_W'(-q_fix) : q_fix;

    logic signed [SAMPLE_W-1:0] r_out_val;
    t_meta                      r_out_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s1_v  <= job.valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_sum   <= sum_c;
            r_s1_cnt   <= cnt_c;
            r_s1_meta  <= job.meta;
            r_s2_x     <= x_c;
            r_s2_cnt   <= r_s1_cnt;
            r_s2_neg   <= r_s1_sum[SUM_W-1];
            r_s2_meta  <= r_s1_meta;
            r_s3_q0    <= prod[RECIP_SH +: MAG_W];
            r_s3_x     <= r_s2_x;
            r_s3_cnt   <= r_s2_cnt;
            r_s3_neg   <= r_s2_neg;
            r_s3_meta  <= r_s2_meta;
            r_out_val  <= q_sgn[SAMPLE_W-1:0];
            r_out_meta <= r_s3_meta;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.smoothed_value = r_out_val;
    assign o_res.out_row        = r_out_meta.row;
    assign o_res.out_col        = r_out_meta.col;
    assign o_res.last_of_burst  = r_out_meta.last;
    assign o_res.frame_done     = r_out_meta.done;

endmodule

>>> rtl/core/enbb3_checker.sv
// Port-level checks for the box mean unit, bound to the top level.
// Depends on enbb3_pkg and edge_normalized_box_blur_3x3_unit.
module enbb3_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   res_valid,
    input logic                                   res_ready,
    input logic signed [enbb3_pkg::SAMPLE_W-1:0]  res_value,
    input logic [enbb3_pkg::ROW_W-1:0]            res_row,
    input logic [enbb3_pkg::COL_W-1:0]            res_col,
    input logic                                   res_last,
    input logic                                   res_done
);
    import enbb3_pkg::*;

    // a stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_row)
            && $stable(res_col) && $stable(res_last) && $stable(res_done))
        else $error("result word changed while stalled");

    // the end of a frame always closes a burst
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_done |-> res_last)
        else $error("frame_done without last_of_burst");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid)
        else $error("result valid right after reset");

endmodule

bind edge_normalized_box_blur_3x3_unit enbb3_checker u_enbb3_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .res_value (o_res.smoothed_value),
    .res_row   (o_res.out_row),
    .res_col   (o_res.out_col),
    .res_last  (o_res.last_of_burst),
    .res_done  (o_res.frame_done)
);
